FILE: hdl/elp_pkg.sv
`timescale 1ns / 1ps

package elp_pkg;

  localparam int LightW = 18;
  localparam int PixW   = 8;
  localparam int IdxW   = 3;

  localparam logic [IdxW-1:0] REG_LIGHT_X  = 3'd0;
  localparam logic [IdxW-1:0] REG_LIGHT_Y  = 3'd1;
  localparam logic [IdxW-1:0] REG_LIGHT_Z  = 3'd2;
  localparam logic [IdxW-1:0] REG_AMBIENT  = 3'd3;
  localparam logic [IdxW-1:0] REG_SPECULAR = 3'd4;

  localparam int SqrtSteps = 9;
  localparam int DivSteps  = 14;
  localparam int PowSteps  = 15;

  localparam int StSum     = 1;
  localparam int StSqrt    = 2;
  localparam int StDiv     = StSqrt + SqrtSteps;
  localparam int StMul     = StDiv + DivSteps;
  localparam int StHigh    = StMul + 1;
  localparam int StPow     = StHigh + 1;
  localparam int NumStages = StPow + PowSteps;

  typedef struct packed {
    logic               vld;
    logic               pos;
    logic signed [27:0] pnx;
    logic signed [27:0] pny;
    logic [16:0]        sqx;
    logic [16:0]        sqy;
    logic signed [27:0] numer;
    logic [17:0]        rad;
    logic [17:0]        root;
    logic [26:0]        rem;
    logic [13:0]        quo;
    logic [7:0]         mul;
    logic signed [26:0] prod;
    logic [7:0]         hl;
    logic [7:0]         add;
  } stage_t;

endpackage

FILE: hdl/emboss_lighting_pixel.sv
`timescale 1ns / 1ps

// emboss lighting, one pixel of an alpha mask per word
// input channel in_valid/in_ready carries the center alpha, four neighbours
// and an edge flag per neighbour; a neighbour whose edge flag is set is replaced by center
// output channel out_valid/out_ready carries multiply_value and additive_value
// configuration is a plain write port (cfg_write, cfg_index, cfg_data):
// 0 light_x, 1 light_y, 2 light_z (signed 2.16), 3 ambient, 4 specular 4.4;
// write it only while no word is in flight
// 42 register stages: two stages of products and sums, nine square root
// stages, fourteen divider stages, two shading stages and fifteen stages of
// the specular power chain, one step per stage
// throughput is one word per cycle while the receiver does not stall;
// the whole pipeline advances together
// when the receiver stalls, the pipeline holds and in_ready drops until the
// last stage is taken; nothing is dropped or repeated
// reset empties the pipeline and loads the light to (0, 0, 1.0), ambient 0
// and specular 0

module emboss_lighting_pixel (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [elp_pkg::IdxW-1:0]  cfg_index,
  input  logic [elp_pkg::LightW-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [elp_pkg::PixW-1:0]  center,
  input  logic [elp_pkg::PixW-1:0]  left,
  input  logic [elp_pkg::PixW-1:0]  right,
  input  logic [elp_pkg::PixW-1:0]  above,
  input  logic [elp_pkg::PixW-1:0]  below,
  input  logic                      at_left_edge,
  input  logic                      at_right_edge,
  input  logic                      at_top_edge,
  input  logic                      at_bottom_edge,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [elp_pkg::PixW-1:0]  multiply_value,
  output logic [elp_pkg::PixW-1:0]  additive_value
);
  import elp_pkg::*;

  logic signed [LightW-1:0] light_x;
  logic signed [LightW-1:0] light_y;
  logic signed [LightW-1:0] light_z;
  logic [7:0]               ambient_level;
  logic [7:0]               specular_power;

  stage_t pipe [NumStages];
  stage_t nxt  [NumStages];
  logic   en;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_x        <= '0;
      light_y        <= '0;
      light_z        <= 18'sd65536;
      ambient_level  <= '0;
      specular_power <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LIGHT_X:  light_x        <= cfg_data;
        REG_LIGHT_Y:  light_y        <= cfg_data;
        REG_LIGHT_Z:  light_z        <= cfg_data;
        REG_AMBIENT:  ambient_level  <= cfg_data[7:0];
        REG_SPECULAR: specular_power <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign en       = !pipe[NumStages-1].vld || out_ready;
  assign in_ready = en;

  // edge substitution, gradients and products
  always_comb begin
    logic [7:0]         l, r, a, b;
    logic signed [27:0] nxw, nyw;
    logic signed [17:0] nxs, nys;
    nxt[0] = pipe[0];
    l   = at_left_edge   ? center : left;
    r   = at_right_edge  ? center : right;
    a   = at_top_edge    ? center : above;
    b   = at_bottom_edge ? center : below;
    nxs = $signed({10'b0, r}) - $signed({10'b0, l});
    nys = $signed({10'b0, b}) - $signed({10'b0, a});
    nxw = 28'(nxs);
    nyw = 28'(nys);
    nxt[0].vld = in_valid;
    nxt[0].pnx = 28'(light_x) * nxw;
    nxt[0].pny = 28'(light_y) * nyw;
    nxt[0].sqx = 17'(nxs * nxs);
    nxt[0].sqy = 17'(nys * nys);
  end

  for (genvar s = 1; s < NumStages; s++) begin : g_stage
    if (s == StSum) begin : g_sum
      always_comb begin
        nxt[s]       = pipe[s-1];
        nxt[s].numer = pipe[s-1].pnx + pipe[s-1].pny + (28'(light_z) <<< 5);
        nxt[s].pos   = (pipe[s-1].pnx + pipe[s-1].pny + (28'(light_z) <<< 5)) > 28'sd0;
        nxt[s].rad   = 18'(pipe[s-1].sqx) + 18'(pipe[s-1].sqy) + 18'd1024;
        nxt[s].root  = '0;
      end
    end else if (s < StDiv) begin : g_sqrt
      always_comb begin
        logic [17:0] bitv;
        logic [18:0] trial;
        nxt[s] = pipe[s-1];
        bitv   = 18'd1 << (16 - 2 * (s - StSqrt));
        trial  = {1'b0, pipe[s-1].root} + {1'b0, bitv};
        if ({1'b0, pipe[s-1].rad} >= trial) begin
          nxt[s].rad  = pipe[s-1].rad - trial[17:0];
          nxt[s].root = (pipe[s-1].root >> 1) + bitv;
        end else begin
          nxt[s].root = pipe[s-1].root >> 1;
        end
      end
    end else if (s < StMul) begin : g_div
      always_comb begin
        logic [30:0] dsh;
        logic [26:0] r0;
        logic [13:0] q0;
        nxt[s] = pipe[s-1];
        r0  = (s == StDiv) ? pipe[s-1].numer[26:0] : pipe[s-1].rem;
        q0  = (s == StDiv) ? 14'd0 : pipe[s-1].quo;
        dsh = {14'b0, pipe[s-1].root[8:0], 8'b0} << (DivSteps - 1 - (s - StDiv));
        nxt[s].rem = r0;
        nxt[s].quo = q0;
        if ({4'b0, r0} >= dsh) begin
          nxt[s].rem = r0 - dsh[26:0];
          nxt[s].quo[DivSteps - 1 - (s - StDiv)] = 1'b1;
        end
      end
    end else if (s == StMul) begin : g_mul
      always_comb begin
        logic [14:0]        m;
        logic signed [16:0] dotw, lz8w, t;
        nxt[s] = pipe[s-1];
        m    = 15'(ambient_level) + 15'(pipe[s-1].quo);
        dotw = $signed({2'b0, pipe[s-1].quo, 1'b0});
        lz8w = {{7{light_z[17]}}, light_z[17:8]};
        t    = dotw - lz8w;
        nxt[s].mul  = !pipe[s-1].pos ? ambient_level : (m > 15'd255 ? 8'd255 : m[7:0]);
        nxt[s].prod = 27'(t) * 27'(lz8w);
      end
    end else if (s == StHigh) begin : g_high
      always_comb begin
        logic [18:0] h;
        nxt[s] = pipe[s-1];
        h      = pipe[s-1].prod[26:8];
        nxt[s].hl = '0;
        if (pipe[s-1].pos && pipe[s-1].prod >= 27'sd256) begin
          nxt[s].hl = (h > 19'd255) ? 8'd255 : h[7:0];
        end
        nxt[s].add = nxt[s].hl;
      end
    end else begin : g_pow
      always_comb begin
        logic [15:0] x;
        logic [32:0] y;
        nxt[s] = pipe[s-1];
        x = {8'b0, pipe[s-1].add} * {8'b0, pipe[s-1].hl};
        y = {1'b0, x, 16'b0} + {9'b0, x, 8'b0} + {17'b0, x};
        if (4'(s - StPow) < specular_power[7:4]) begin
          nxt[s].add = y[31:24];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NumStages; s++) begin
        pipe[s].vld <= 1'b0;
      end
    end else if (en) begin
      for (int s = 0; s < NumStages; s++) begin
        pipe[s] <= nxt[s];
      end
    end
  end

  assign out_valid      = pipe[NumStages-1].vld;
  assign multiply_value = pipe[NumStages-1].mul;
  assign additive_value = pipe[NumStages-1].add;

  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> pipe[0].vld)
    else $error("accepted word did not enter the pipeline");

  a_root: assert property (@(posedge clk) disable iff (rst)
    pipe[StDiv-1].vld |-> pipe[StDiv-1].root >= 18'd32 && pipe[StDiv-1].root < 18'd363)
    else $error("normal length out of range");

  a_div: assert property (@(posedge clk) disable iff (rst)
    pipe[StMul-1].vld && pipe[StMul-1].pos |->
      {4'b0, pipe[StMul-1].rem} < {14'b0, pipe[StMul-1].root[8:0], 8'b0})
    else $error("divider remainder not below divisor");

  a_ambient: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> multiply_value >= ambient_level)
    else $error("multiply value below ambient");

endmodule
